>>> hdl/fractional_delay_allpass_macros.svh
// Assertion macros shared by the allpass block.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef FRACTIONAL_DELAY_ALLPASS_MACROS_SVH
`define FRACTIONAL_DELAY_ALLPASS_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define FDAP_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define FDAP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define FDAP_ASSERT_NOW(lbl, pre, post, msg)
`define FDAP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> hdl/fdap_pkg.sv
`default_nettype none

package fdap_pkg;

  // Default sizes of the block.
  localparam int DEFAULT_RING_DEPTH  = 65536;
  localparam int DEFAULT_SAMPLE_BITS = 24;

  // Register file layout.
  localparam int DELAY_BITS = 24;
  localparam int GAIN_BITS  = 16;
  localparam logic REG_DELAY = 1'b0;
  localparam logic REG_GAIN  = 1'b1;

  // Delay has 8 fraction bits; gain is Q1.15.
  localparam int FRAC_BITS = 8;
  localparam int GAIN_FRAC = 15;
  localparam int ACC_FRAC  = GAIN_FRAC + FRAC_BITS;
  localparam logic [GAIN_BITS:0] GAIN_ONE = 17'd32768;

  // Sequencer states for one word.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_TAP,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_t;

  // Where a history tap takes its value from.
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_MEM,
    SRC_NEW
  } src_t;

endpackage

`default_nettype wire

>>> hdl/fdap_ring.sv
`default_nettype none

module fdap_ring #(
  parameter int DEPTH     = 65536,
  parameter int WIDTH     = 24,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output      logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hdl/fractional_delay_allpass.sv
// Fractional-delay allpass section with linearly interpolated history taps.
// Input channel: in_valid / in_stall with sample_in, one signed sample per word.
// Output channel: out_valid / out_stall with sample_out, one result per input word.
// Configuration: wr_en with wr_index and wr_data writes the delay (index 0, Q16.8)
// or the feedback gain (index 1, Q1.15); write only while the block is idle.
// The result is registered in the FIN step, after the RD1, TAP, MUL and ACC steps.
// Words are processed one at a time, set by the single read port of each
// history RAM (two interpolation reads per word) and the two chained multiplies.
// The next word is taken while the previous result still waits in the output
// register; a stalled result holds the sequencer in its last step only when a
// second result is ready to be written.
// Reset stalls the input and clears the write position, the registers and the output
// valid. The history RAMs are not swept: entries not yet written since reset read as
// zero through a fill mark, so words are taken from the first cycle after reset.
`default_nettype none
`include "fractional_delay_allpass_macros.svh"

module fractional_delay_allpass #(
  parameter int RING_DEPTH  = fdap_pkg::DEFAULT_RING_DEPTH,
  parameter int SAMPLE_BITS = fdap_pkg::DEFAULT_SAMPLE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]  sample_in,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic signed [SAMPLE_BITS-1:0]  sample_out,
  input  wire logic                           wr_en,
  input  wire logic                           wr_index,
  input  wire logic [fdap_pkg::DELAY_BITS-1:0] wr_data
);

  import fdap_pkg::*;

  localparam int AW     = $clog2(RING_DEPTH);
  localparam int PW     = AW + FRAC_BITS;
  localparam int DW     = ((PW > DELAY_BITS) ? PW : DELAY_BITS) + 1;
  localparam int TW     = SAMPLE_BITS + 10;
  localparam int ACC_W  = SAMPLE_BITS + 30;
  localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);
  localparam logic [DW-1:0] SPAN = DW'(RING_DEPTH) << FRAC_BITS;
  localparam logic [63:0] DELAY_LIMIT = 64'(RING_DEPTH - 1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W - ACC_FRAC){1'b0}}, 1'b1, {(ACC_FRAC - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  // Control state.
  state_t state, state_next;
  logic [AW-1:0] wp;
  logic [AW-1:0] wp_next;
  logic          wrapped;
  logic [DELAY_BITS-1:0] delay;
  logic [GAIN_BITS-1:0]  gain;
  logic in_accept;
  logic fin_go;

  // Per-word payload registers.
  logic signed [SAMPLE_BITS-1:0] x;
  logic [AW-1:0] idx0, idx1;
  logic [FRAC_BITS-1:0] frac;
  src_t src_in0, src_in1, src_out0, src_out1;
  logic signed [TW-1:0] prod_in, prod_out, tap_in, tap_out;
  logic signed [ACC_W-1:0] p_in, acc;

  // Read position and RAM interface.
  logic [DW-1:0] pos_raw, pos_wrap;
  logic [AW-1:0] pos_idx, pos_idx_nb;
  logic [FRAC_BITS-1:0] pos_frac;
  logic [AW-1:0] rd_addr;
  logic [SAMPLE_BITS-1:0] rd_in, rd_out;
  logic signed [SAMPLE_BITS-1:0] h_in, h_out;
  logic [FRAC_BITS:0] w0;
  logic signed [ACC_W-1:0] y_full;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  // Decides where a tap comes from: the word being processed, the RAM, or the
  // reset value for entries not written since reset.
  function automatic src_t pick_src(input logic [AW-1:0] idx, input logic [AW-1:0] pos,
                                    input logic filled, input logic is_input);
    src_t s;
    if (is_input && idx == pos) begin
      s = SRC_NEW;
    end else if (filled || idx < pos) begin
      s = SRC_MEM;
    end else begin
      s = SRC_ZERO;
    end
    return s;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_val(
      input src_t s, input logic [SAMPLE_BITS-1:0] m, input logic signed [SAMPLE_BITS-1:0] n);
    logic signed [SAMPLE_BITS-1:0] v;
    case (s)
      SRC_MEM: v = $signed(m);
      SRC_NEW: v = n;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Read position: write position minus delay, wrapped by the ring span.
  always_comb begin
    pos_raw  = DW'({wp, {FRAC_BITS{1'b0}}}) - DW'(delay);
    pos_wrap = pos_raw[DW-1] ? pos_raw + SPAN : pos_raw;
    pos_idx  = pos_wrap[PW-1:FRAC_BITS];
    pos_frac = pos_wrap[FRAC_BITS-1:0];
    pos_idx_nb = (pos_idx == LAST) ? '0 : pos_idx + 1'b1;
  end

  // Sequencer: next state and handshake.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    fin_go     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = rst;
        if (in_valid) begin
          state_next = ST_RD1;
        end
      end
      ST_RD1: state_next = ST_TAP;
      ST_TAP: state_next = ST_MUL;
      ST_MUL: state_next = ST_ACC;
      ST_ACC: state_next = ST_FIN;
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          fin_go     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_accept = in_valid && !in_stall;
  assign wp_next   = (wp == LAST) ? '0 : wp + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Position, fill mark, registers and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      wrapped   <= 1'b0;
      delay     <= '0;
      gain      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_DELAY: delay <= (64'(wr_data) >= DELAY_LIMIT) ? '0 : wr_data;
          REG_GAIN: begin
            gain <= ({1'b0, wr_data[GAIN_BITS-1:0]} > GAIN_ONE) ?
                    GAIN_ONE[GAIN_BITS-1:0] : wr_data[GAIN_BITS-1:0];
          end
          default: ;
        endcase
      end
      if (fin_go) begin
        wp <= wp_next;
        if (wp == LAST) begin
          wrapped <= 1'b1;
        end
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The first tap is read at the accept edge, the neighbor in the cycle after, in ST_RD1.
  assign rd_addr = (state == ST_IDLE) ? pos_idx : idx1;

  fdap_ring #(
    .DEPTH     (RING_DEPTH),
    .WIDTH     (SAMPLE_BITS),
    .ADDR_BITS (AW)
  ) u_in_ring (
    .clk     (clk),
    .wr_en   (in_accept),
    .wr_addr (wp),
    .wr_data (sample_in),
    .rd_addr (rd_addr),
    .rd_data (rd_in)
  );

  fdap_ring #(
    .DEPTH     (RING_DEPTH),
    .WIDTH     (SAMPLE_BITS),
    .ADDR_BITS (AW)
  ) u_out_ring (
    .clk     (clk),
    .wr_en   (fin_go),
    .wr_addr (wp),
    .wr_data (y_sat),
    .rd_addr (rd_addr),
    .rd_data (rd_out)
  );

  // Tap values with forwarding of the new word and the fill mark applied.
  always_comb begin
    h_in  = pick_val((state == ST_RD1) ? src_in0 : src_in1, rd_in, x);
    h_out = pick_val((state == ST_RD1) ? src_out0 : src_out1, rd_out, x);
    w0    = (FRAC_BITS + 1)'(1 << FRAC_BITS) - {1'b0, frac};
  end

  // Rounding to the sample grid and saturation.
  always_comb begin
    y_full = acc >>> ACC_FRAC;
    if (y_full > SAT_MAX) begin
      y_sat = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (y_full < SAT_MIN) begin
      y_sat = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_full[SAMPLE_BITS-1:0];
    end
  end

  // Datapath: interpolate both taps, then sum the two gain products less the input word.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      x        <= sample_in;
      idx0     <= pos_idx;
      idx1     <= pos_idx_nb;
      frac     <= pos_frac;
      src_in0  <= pick_src(pos_idx, wp, wrapped, 1'b1);
      src_in1  <= pick_src(pos_idx_nb, wp, wrapped, 1'b1);
      src_out0 <= pick_src(pos_idx, wp, wrapped, 1'b0);
      src_out1 <= pick_src(pos_idx_nb, wp, wrapped, 1'b0);
    end
    if (state == ST_RD1) begin
      prod_in  <= TW'($signed({1'b0, w0})) * TW'(h_in);
      prod_out <= TW'($signed({1'b0, w0})) * TW'(h_out);
    end
    if (state == ST_TAP) begin
      tap_in  <= prod_in + TW'($signed({1'b0, frac})) * TW'(h_in);
      tap_out <= prod_out + TW'($signed({1'b0, frac})) * TW'(h_out);
    end
    if (state == ST_MUL) begin
      p_in <= ACC_W'($signed({1'b0, GAIN_ONE + {1'b0, gain}})) * ACC_W'(tap_in);
    end
    if (state == ST_ACC) begin
      acc <= p_in + ACC_W'($signed({1'b0, gain})) * ACC_W'(tap_out)
             - (ACC_W'(x) <<< ACC_FRAC) + ROUND_HALF;
    end
    if (fin_go) begin
      sample_out <= y_sat;
    end
  end

  // The write position holds while a word is being worked on.
  `FDAP_ASSERT_NEXT(a_wp_hold, state != ST_IDLE && state != ST_FIN, $stable(wp), "write position moved mid-word")
  // The neighbor tap is the next ring entry, wrapping at the end.
  `FDAP_ASSERT_NOW(a_neighbor, state == ST_TAP, (idx1 == idx0 + 1'b1) || (idx0 == LAST && idx1 == '0), "neighbor tap index wrong")
  // Before the ring has wrapped, only written entries are read from the output RAM.
  `FDAP_ASSERT_NOW(a_fill_mark, state == ST_TAP && !wrapped && src_out0 == SRC_MEM, idx0 < wp, "unwritten output entry used")
  // A finished word moves to the output register and frees the sequencer.
  `FDAP_ASSERT_NEXT(a_fin_out, state == ST_FIN && !(out_valid && out_stall), out_valid && state == ST_IDLE, "result not delivered")

endmodule

`default_nettype wire
